FILE: src/rrs_pkg.sv
// Shared constants, types and state encoding for the round-robin scheduler.
`default_nettype none

package rrs_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Fixed field widths
    localparam int SLOT_W = 4;
    localparam int SEC_W  = 6;
    localparam int LEN_W  = 6;
    localparam int SUM_W  = SEC_W + 1;
    localparam int CMP_W  = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

    localparam int SECONDS_PER_MINUTE = 60;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [SEC_W-1:0]  sec_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [CMP_W-1:0]  cmp_t;

    localparam sec_t SEC_LAST = sec_t'(SECONDS_PER_MINUTE - 1);

    // Item and entry codes
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    localparam logic KIND_RR   = 1'b0;
    localparam logic KIND_RT   = 1'b1;

    typedef struct packed {
        logic kind;
        sec_t start;
        len_t length;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_END,
        ST_SCAN,
        ST_ROTATE,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic add_wr;
        logic tick_acc;
        logic end_chk;
        logic scan_en;
        logic rotate;
        logic finish_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: src/rrs_if.sv
// Valid/ready channel interfaces for scheduler items and results.
`default_nettype none

interface rrs_item_if;
    logic               valid;
    logic               ready;
    logic               mode;
    rrs_pkg::slot_t     slot;
    logic               kind;
    rrs_pkg::sec_t      start_second;
    rrs_pkg::len_t      run_seconds;

    modport source (output valid, output mode, output slot, output kind,
                    output start_second, output run_seconds, input ready);
    modport sink   (input valid, input mode, input slot, input kind,
                    input start_second, input run_seconds, output ready);
endinterface

interface rrs_result_if;
    logic               valid;
    logic               ready;
    rrs_pkg::slot_t     running_slot;
    logic               running_active;
    logic               realtime_active;
    logic               rejected;
    rrs_pkg::slot_t     rejected_slot;
    rrs_pkg::sec_t      second_now;

    modport source (output valid, output running_slot, output running_active,
                    output realtime_active, output rejected, output rejected_slot,
                    output second_now, input ready);
    modport sink   (input valid, input running_slot, input running_active,
                    input realtime_active, input rejected, input rejected_slot,
                    input second_now, output ready);
endinterface

`default_nettype wire

FILE: src/rrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/rrs_ctrl.sv
// Tick sequencer: steps a tick through end check, table scan, rotation and result load.
`default_nettype none

module rrs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_mode,
    output logic                  in_ready,
    input  wire rrs_pkg::status_t status,
    output rrs_pkg::cmd_t         cmd
);

    rrs_pkg::state_t state_reg;
    rrs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrs_pkg::ST_IDLE:
            begin
                if (in_valid && (in_mode == rrs_pkg::MODE_TICK))
                begin
                    state_next = rrs_pkg::ST_END;
                end
            end
            rrs_pkg::ST_END:
            begin
                state_next = rrs_pkg::ST_SCAN;
            end
            rrs_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = rrs_pkg::ST_ROTATE;
                end
            end
            rrs_pkg::ST_ROTATE:
            begin
                state_next = rrs_pkg::ST_FINISH;
            end
            rrs_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = rrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            rrs_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.add_wr   = in_valid && (in_mode == rrs_pkg::MODE_ADD);
                cmd.tick_acc = in_valid && (in_mode == rrs_pkg::MODE_TICK);
            end
            rrs_pkg::ST_END:
            begin
                cmd.end_chk = 1'b1;
            end
            rrs_pkg::ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
            end
            rrs_pkg::ST_ROTATE:
            begin
                cmd.rotate = 1'b1;
            end
            rrs_pkg::ST_FINISH:
            begin
                cmd.finish_load = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/rrs_datapath.sv
// Scheduler state, entry table and ring memories, scan pipeline and result register.
`default_nettype none

module rrs_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rrs_pkg::cmd_t    cmd,
    output rrs_pkg::status_t      status,
    input  wire rrs_pkg::slot_t   slot,
    input  wire logic             kind,
    input  wire rrs_pkg::sec_t    start_second,
    input  wire rrs_pkg::len_t    run_seconds,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output rrs_pkg::slot_t        running_slot,
    output logic                  running_active,
    output logic                  realtime_active,
    output logic                  rejected,
    output rrs_pkg::slot_t        rejected_slot,
    output rrs_pkg::sec_t         second_now
);

    localparam rrs_pkg::cnt_t N_CNT = rrs_pkg::cnt_t'(rrs_pkg::TABLE_ENTRIES);

    // Scheduler state
    logic [rrs_pkg::TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [rrs_pkg::TABLE_ENTRIES-1:0] admitted_reg, admitted_next;
    rrs_pkg::cnt_t ring_count_reg, ring_count_next;
    rrs_pkg::idx_t ring_ptr_reg, ring_ptr_next;
    rrs_pkg::idx_t cur_slot_reg, cur_slot_next;
    logic          cur_valid_reg, cur_valid_next;
    logic          busy_reg, busy_next;
    logic          held_reg, held_next;
    rrs_pkg::sec_t sec_reg, sec_next;

    // Per-tick working registers
    rrs_pkg::sec_t now_reg, now_next;
    logic          rej_reg, rej_next;
    rrs_pkg::idx_t rej_slot_reg, rej_slot_next;
    rrs_pkg::cnt_t scan_idx_reg, scan_idx_next;
    logic          proc_vld_reg, proc_vld_next;
    rrs_pkg::idx_t proc_idx_reg, proc_idx_next;

    // Result register
    logic           out_valid_reg, out_valid_next;
    rrs_pkg::slot_t out_slot_reg, out_slot_next;
    logic           out_run_reg, out_run_next;
    logic           out_rt_reg, out_rt_next;
    logic           out_rej_reg, out_rej_next;
    rrs_pkg::slot_t out_rej_slot_reg, out_rej_slot_next;
    rrs_pkg::sec_t  out_sec_reg, out_sec_next;

    // Memory ports
    logic            entry_wr_en;
    rrs_pkg::idx_t   entry_wr_addr;
    rrs_pkg::entry_t entry_wr_data;
    rrs_pkg::idx_t   entry_rd_addr;
    rrs_pkg::entry_t entry_rd_data;
    logic            ring_wr_en;
    rrs_pkg::idx_t   ring_rd_addr;
    rrs_pkg::idx_t   ring_rd_data;

    logic          slot_ok;
    logic          ptr_wrap;
    rrs_pkg::idx_t ptr_eff;
    rrs_pkg::cnt_t ptr_inc;
    rrs_pkg::sum_t window_end;
    logic          proc_entry_valid;

    rrs_ram #(
        .WIDTH (rrs_pkg::ENTRY_W),
        .DEPTH (rrs_pkg::TABLE_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (entry_wr_en),
        .wr_addr (entry_wr_addr),
        .wr_data (entry_wr_data),
        .rd_addr (entry_rd_addr),
        .rd_data (entry_rd_data)
    );

    rrs_ram #(
        .WIDTH (rrs_pkg::IDX_W),
        .DEPTH (rrs_pkg::TABLE_ENTRIES)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_count_reg[rrs_pkg::IDX_W-1:0]),
        .wr_data (proc_idx_reg),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    always_comb
    begin
        slot_ok = rrs_pkg::cmp_t'(slot) < rrs_pkg::cmp_t'(rrs_pkg::TABLE_ENTRIES);

        entry_wr_en          = cmd.add_wr && slot_ok;
        entry_wr_addr        = rrs_pkg::idx_t'(slot);
        entry_wr_data.kind   = kind;
        entry_wr_data.start  = start_second;
        entry_wr_data.length = run_seconds;
        // Point at the scan entry while scanning, at the current task otherwise
        entry_rd_addr = cmd.scan_en ? scan_idx_reg[rrs_pkg::IDX_W-1:0] : cur_slot_reg;

        ptr_wrap     = rrs_pkg::cnt_t'(ring_ptr_reg) >= ring_count_reg;
        ptr_eff      = ptr_wrap ? '0 : ring_ptr_reg;
        ptr_inc      = rrs_pkg::cnt_t'(ptr_eff) + rrs_pkg::cnt_t'(1);
        ring_rd_addr = ptr_eff;

        window_end = rrs_pkg::sum_t'(entry_rd_data.start) +
                     rrs_pkg::sum_t'(entry_rd_data.length);

        proc_entry_valid = valid_reg[proc_idx_reg];
        ring_wr_en = proc_vld_reg && proc_entry_valid && !admitted_reg[proc_idx_reg] &&
                     (entry_rd_data.kind == rrs_pkg::KIND_RR) && (ring_count_reg < N_CNT);
    end

    always_comb
    begin
        valid_next        = valid_reg;
        admitted_next     = admitted_reg;
        ring_count_next   = ring_count_reg;
        ring_ptr_next     = ring_ptr_reg;
        cur_slot_next     = cur_slot_reg;
        cur_valid_next    = cur_valid_reg;
        busy_next         = busy_reg;
        held_next         = held_reg;
        sec_next          = sec_reg;
        now_next          = now_reg;
        rej_next          = rej_reg;
        rej_slot_next     = rej_slot_reg;
        scan_idx_next     = scan_idx_reg;
        proc_vld_next     = proc_vld_reg;
        proc_idx_next     = proc_idx_reg;
        out_valid_next    = out_valid_reg;
        out_slot_next     = out_slot_reg;
        out_run_next      = out_run_reg;
        out_rt_next       = out_rt_reg;
        out_rej_next      = out_rej_reg;
        out_rej_slot_next = out_rej_slot_reg;
        out_sec_next      = out_sec_reg;

        if (entry_wr_en)
        begin
            valid_next[entry_wr_addr] = 1'b1;
        end

        // Latch the second and advance the minute counter
        if (cmd.tick_acc)
        begin
            now_next      = sec_reg;
            sec_next      = (sec_reg == rrs_pkg::SEC_LAST) ? '0 : sec_reg + rrs_pkg::sec_t'(1);
            rej_next      = 1'b0;
            rej_slot_next = '0;
            scan_idx_next = '0;
            proc_vld_next = 1'b0;
        end

        // Hold all tasks at second zero; end the running window on time
        if (cmd.end_chk)
        begin
            if (now_reg == '0)
            begin
                held_next = 1'b1;
            end
            if (busy_reg && cur_valid_reg && valid_reg[cur_slot_reg] &&
                (entry_rd_data.kind == rrs_pkg::KIND_RT) &&
                (window_end == rrs_pkg::sum_t'(now_reg)))
            begin
                cur_valid_next = 1'b0;
                cur_slot_next  = '0;
                busy_next      = 1'b0;
            end
        end

        // Issue one table read per cycle
        if (cmd.scan_en)
        begin
            if (scan_idx_reg < N_CNT)
            begin
                proc_vld_next = 1'b1;
                proc_idx_next = scan_idx_reg[rrs_pkg::IDX_W-1:0];
                scan_idx_next = scan_idx_reg + rrs_pkg::cnt_t'(1);
            end
            else
            begin
                proc_vld_next = 1'b0;
            end
        end

        // Admit and start on the entry whose read data just returned
        if (proc_vld_reg && proc_entry_valid)
        begin
            if (!admitted_reg[proc_idx_reg])
            begin
                admitted_next[proc_idx_reg] = 1'b1;
            end
            if (ring_wr_en)
            begin
                ring_count_next = ring_count_reg + rrs_pkg::cnt_t'(1);
                ring_ptr_next   = '0;
            end
            if ((entry_rd_data.kind == rrs_pkg::KIND_RT) && (entry_rd_data.start == now_reg))
            begin
                if (busy_reg)
                begin
                    rej_next      = 1'b1;
                    rej_slot_next = proc_idx_reg;
                end
                else
                begin
                    cur_slot_next  = proc_idx_reg;
                    cur_valid_next = 1'b1;
                    busy_next      = 1'b1;
                    held_next      = 1'b0;
                end
            end
        end

        // Advance the ring when no real-time window is open
        if (cmd.rotate && !busy_reg && (ring_count_reg != '0))
        begin
            cur_slot_next  = ring_rd_data;
            cur_valid_next = 1'b1;
            held_next      = 1'b0;
            ring_ptr_next  = (ptr_inc >= ring_count_reg) ? '0 :
                             ptr_inc[rrs_pkg::IDX_W-1:0];
        end

        if (cmd.finish_load)
        begin
            out_valid_next    = 1'b1;
            out_slot_next     = cur_valid_reg ? rrs_pkg::slot_t'(cur_slot_reg) : '0;
            out_run_next      = cur_valid_reg && !held_reg;
            out_rt_next       = cur_valid_reg && busy_reg;
            out_rej_next      = rej_reg;
            out_rej_slot_next = rrs_pkg::slot_t'(rej_slot_reg);
            out_sec_next      = now_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            admitted_reg   <= '0;
            ring_count_reg <= '0;
            ring_ptr_reg   <= '0;
            cur_slot_reg   <= '0;
            cur_valid_reg  <= 1'b0;
            busy_reg       <= 1'b0;
            held_reg       <= 1'b0;
            sec_reg        <= '0;
            rej_reg        <= 1'b0;
            rej_slot_reg   <= '0;
            scan_idx_reg   <= '0;
            proc_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            admitted_reg   <= admitted_next;
            ring_count_reg <= ring_count_next;
            ring_ptr_reg   <= ring_ptr_next;
            cur_slot_reg   <= cur_slot_next;
            cur_valid_reg  <= cur_valid_next;
            busy_reg       <= busy_next;
            held_reg       <= held_next;
            sec_reg        <= sec_next;
            rej_reg        <= rej_next;
            rej_slot_reg   <= rej_slot_next;
            scan_idx_reg   <= scan_idx_next;
            proc_vld_reg   <= proc_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg          <= now_next;
        proc_idx_reg     <= proc_idx_next;
        out_slot_reg     <= out_slot_next;
        out_run_reg      <= out_run_next;
        out_rt_reg       <= out_rt_next;
        out_rej_reg      <= out_rej_next;
        out_rej_slot_reg <= out_rej_slot_next;
        out_sec_reg      <= out_sec_next;
    end

    assign status.scan_done = (scan_idx_reg == N_CNT) && !proc_vld_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign running_slot    = out_slot_reg;
    assign running_active  = out_run_reg;
    assign realtime_active = out_rt_reg;
    assign rejected        = out_rej_reg;
    assign rejected_slot   = out_rej_slot_reg;
    assign second_now      = out_sec_reg;

`ifndef SYNTHESIS
    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_count_reg <= N_CNT)
        else $error("ring count exceeds table size");

    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (rrs_pkg::cnt_t'(ring_ptr_reg) < ring_count_reg) || (ring_ptr_reg == '0))
        else $error("ring pointer beyond ring fill");

    a_busy_has_task: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cur_valid_reg)
        else $error("real-time window open without a current task");

    a_admit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (admitted_reg & ~valid_reg) == '0)
        else $error("admitted entry never written");

    a_scan_confined: assert property (@(posedge clk) disable iff (!rst_n)
        proc_vld_reg |-> cmd.scan_en)
        else $error("scan data returned outside the scan phase");
`endif

endmodule

`default_nettype wire

FILE: src/realtime_round_robin_scheduler_top.sv
// Top level of the round-robin scheduler with real-time windows.
`default_nettype none

// Task scheduler with a table of TABLE_ENTRIES slots (16). An item with mode 0
// writes a task entry (kind, start second, run length) into its slot; it yields
// no result. An item with mode 1 is a one-second tick and
// yields exactly one result: the block admits new entries (round-robin ones
// join the ring and the ring pointer returns to its head), closes the running
// real-time window when start plus length equals the current second, starts
// real-time tasks whose second has come (refusing and flagging any start while
// a window is open, first slot in order wins), and otherwise rotates to the
// next round-robin task. Second zero holds every task until one is continued.
// A tick keeps the input closed until its result is loaded. Most of that time
// is the scan of the entry table, one entry per cycle through the single read
// port of the entry memory, with a registered read of each entry and a wait
// for the last ring write to settle before the ring is read. The window-end
// check comes before the scan; the ring rotation and the result load follow it.
// The result sits in an output register, so a waiting result does not block
// add items or the next tick; a tick only stalls at its final step if the
// previous result has still not been taken.
module realtime_round_robin_scheduler_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rrs_item_if.sink     item,
    rrs_result_if.source result
);

    rrs_pkg::cmd_t    cmd;
    rrs_pkg::status_t status;

    // Sequence each tick through its phases
    rrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_mode  (item.mode),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the table, ring and result; transfer results out of the register
    rrs_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .slot            (item.slot),
        .kind            (item.kind),
        .start_second    (item.start_second),
        .run_seconds     (item.run_seconds),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .running_slot    (result.running_slot),
        .running_active  (result.running_active),
        .realtime_active (result.realtime_active),
        .rejected        (result.rejected),
        .rejected_slot   (result.rejected_slot),
        .second_now      (result.second_now)
    );

endmodule

`default_nettype wire
